// ===== rtl/vda_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vda_pkg
// Shared widths, pipeline payload types and constants of the draft angle block.
// ----------------------------------------------------------------------------
package vda_pkg;

    // Work width of the dot and cross products before normalization.
    localparam int NW        = 50;
    // Normalized values lie below 2^NORM_BIT.
    localparam int NORM_BIT  = 39;
    // CORDIC x/y width and angle accumulator width.
    localparam int CW        = 43;
    localparam int ZW        = 33;
    localparam int TABLE_LEN = 32;
    // Inverse CORDIC gain in Q20.
    localparam int INV_GAIN  = 636751;
    localparam int GAIN_W    = 21;
    localparam int GAIN_FRAC = 20;
    localparam int DEG90_Q8  = 23040;
    localparam int NORM_CELLS = 11;

    // Normalization cell kinds.
    localparam int MODE_RIGHT_TRY  = 0;
    localparam int MODE_RIGHT_SELF = 1;
    localparam int MODE_LEFT       = 2;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_DIR_X = 2'd0;
    localparam logic [1:0] REG_DIR_Y = 2'd1;
    localparam logic [1:0] REG_DIR_Z = 2'd2;

    typedef logic signed [NW-1:0] wide_t;
    typedef wide_t [3:0] quad_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] tag;
        logic        degen;
    } side_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic signed [CW-1:0] a0;
        logic signed [CW-1:0] a1;
    } cord_t;

    function automatic logic [NW-1:0] mag_w(input logic [NW-1:0] v);
        return v[NW-1] ? (~v + NW'(1)) : v;
    endfunction

    // Shift amount and kind of each normalization cell, in pipeline order.
    function automatic int norm_shift(input int k);
        case (k)
            0:       return 8;
            1:       return 4;
            2:       return 2;
            3:       return 1;
            4:       return 1;
            5:       return 32;
            6:       return 16;
            7:       return 8;
            8:       return 4;
            9:       return 2;
            default: return 1;
        endcase
    endfunction

    function automatic int norm_mode(input int k);
        if (k < 4)
            return MODE_RIGHT_TRY;
        else if (k == 4)
            return MODE_RIGHT_SELF;
        else
            return MODE_LEFT;
    endfunction

    // atan(2^-i) in degrees with 24 fraction bits.
    function automatic logic [31:0] atan_deg(input int i);
        case (i)
            0:       return 32'd754974720;
            1:       return 32'd445687602;
            2:       return 32'd235489088;
            3:       return 32'd119537938;
            4:       return 32'd60000934;
            5:       return 32'd30029717;
            6:       return 32'd15018523;
            7:       return 32'd7509720;
            8:       return 32'd3754917;
            9:       return 32'd1877466;
            10:      return 32'd938734;
            11:      return 32'd469367;
            12:      return 32'd234684;
            13:      return 32'd117342;
            14:      return 32'd58671;
            15:      return 32'd29335;
            16:      return 32'd14668;
            17:      return 32'd7334;
            18:      return 32'd3667;
            19:      return 32'd1833;
            20:      return 32'd917;
            21:      return 32'd458;
            22:      return 32'd229;
            23:      return 32'd115;
            24:      return 32'd57;
            25:      return 32'd29;
            26:      return 32'd14;
            27:      return 32'd7;
            28:      return 32'd4;
            29:      return 32'd2;
            30:      return 32'd1;
            default: return 32'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== rtl/vector_draft_angle.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vector_draft_angle
// Draft angle of a face normal against the demolding direction.
// ----------------------------------------------------------------------------
// The block takes one beat per clock and returns one beat for each, in order.
// A product register and a sum register form the nine products and the dot
// and cross sums, eleven cells scale them by powers of two, then three CORDIC
// chains of N cells each (N is CORDIC_STAGES, at most 32): two lengths, each
// followed by a gain multiply, and the final angle; then one output register.
// The whole pipeline advances whenever the output register is empty or being
// taken, so throughput is one beat per cycle without back-pressure. The
// direction registers may be written only while no beat is in flight.
module vector_draft_angle #(
    parameter int COMPONENT_BITS = 16,
    parameter int CORDIC_STAGES  = 16
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // face_tag[15:0], norm_x, norm_y, norm_z (COMPONENT_BITS each), zero fill
    input  wire [((16+3*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // out_tag[15:0], draft_deg[31:16]
    output logic [31:0]                           m_tdata,
    // degenerate[0]
    output logic                                  m_tuser,
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire [3:0]                             paddr,
    input  wire [31:0]                            pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import vda_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int RW = (CB > 24) ? 24 : CB;
    localparam int NS = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    logic [CB-1:0] dir_x_reg;
    logic [CB-1:0] dir_y_reg;
    logic [CB-1:0] dir_z_reg;
    logic          wr_en;
    logic          en;

    // Configuration port.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_x_reg <= '0;
            dir_y_reg <= '0;
            dir_z_reg <= CB'(32767);
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_DIR_X: dir_x_reg <= pwdata[CB-1:0];
                REG_DIR_Y: dir_y_reg <= pwdata[CB-1:0];
                REG_DIR_Z: dir_z_reg <= pwdata[CB-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_DIR_X: prdata = 32'(dir_x_reg);
            REG_DIR_Y: prdata = 32'(dir_y_reg);
            REG_DIR_Z: prdata = 32'(dir_z_reg);
            default:   prdata = '0;
        endcase
    end

    // Pipeline advance.
    logic out_valid_reg;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Components reduced to at most 24 bits by dropping low bits.
    logic signed [RW-1:0] nx, ny, nz, dx, dy, dz;
    assign nx = s_tdata[16+CB-RW +: RW];
    assign ny = s_tdata[16+2*CB-RW +: RW];
    assign nz = s_tdata[16+3*CB-RW +: RW];
    assign dx = dir_x_reg[CB-1 -: RW];
    assign dy = dir_y_reg[CB-1 -: RW];
    assign dz = dir_z_reg[CB-1 -: RW];

    // Product stage.
    side_t                  p_side_next;
    side_t                  p_side_reg;
    logic signed [2*RW-1:0] prod_reg [9];

    always_comb
    begin
        p_side_next.valid = s_tvalid;
        p_side_next.tag   = s_tdata[15:0];
        p_side_next.degen = (nx == '0 && ny == '0 && nz == '0) ||
                            (dx == '0 && dy == '0 && dz == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_side_reg <= '0;
        else if (en)
            p_side_reg <= p_side_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= nx * dx;
            prod_reg[1] <= ny * dy;
            prod_reg[2] <= nz * dz;
            prod_reg[3] <= ny * dz;
            prod_reg[4] <= nz * dy;
            prod_reg[5] <= nz * dx;
            prod_reg[6] <= nx * dz;
            prod_reg[7] <= nx * dy;
            prod_reg[8] <= ny * dx;
        end
    end

    // Sum stage: element 0 is the dot product, 1 to 3 the cross product.
    quad_t sum_next;
    side_t norm_side [NORM_CELLS+1];
    quad_t norm_vec  [NORM_CELLS+1];
    side_t s_side_reg;
    quad_t s_vec_reg;

    always_comb
    begin
        sum_next[0] = NW'(prod_reg[0]) + NW'(prod_reg[1]) + NW'(prod_reg[2]);
        sum_next[1] = NW'(prod_reg[3]) - NW'(prod_reg[4]);
        sum_next[2] = NW'(prod_reg[5]) - NW'(prod_reg[6]);
        sum_next[3] = NW'(prod_reg[7]) - NW'(prod_reg[8]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_side_reg <= '0;
        else if (en)
            s_side_reg <= p_side_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s_vec_reg <= sum_next;
    end

    assign norm_side[0] = s_side_reg;
    assign norm_vec[0]  = s_vec_reg;

    for (genvar k = 0; k < NORM_CELLS; k++)
    begin : g_norm
        vda_norm_cell #(
            .SHIFT (norm_shift(k)),
            .MODE  (norm_mode(k))
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .side_in  (norm_side[k]),
            .vec_in   (norm_vec[k]),
            .side_out (norm_side[k+1]),
            .vec_out  (norm_vec[k+1])
        );
    end

    // First length pass over (cx, cy), carrying dot and cz along.
    side_t c1_side [NS+1];
    cord_t c1_vec  [NS+1];
    side_t c2_side [NS+1];
    cord_t c2_vec  [NS+1];
    side_t c3_side [NS+1];
    cord_t c3_vec  [NS+1];
    side_t g1_side, g2_side;
    cord_t g1_vec, g2_vec;

    always_comb
    begin
        c1_vec[0].x  = CW'(mag_w(norm_vec[NORM_CELLS][1]));
        c1_vec[0].y  = CW'(norm_vec[NORM_CELLS][2]);
        c1_vec[0].z  = '0;
        c1_vec[0].a0 = CW'(norm_vec[NORM_CELLS][0]);
        c1_vec[0].a1 = CW'(norm_vec[NORM_CELLS][3]);
    end
    assign c1_side[0] = norm_side[NORM_CELLS];

    for (genvar i = 0; i < NS; i++)
    begin : g_pass1
        vda_cordic_cell #(.STAGE(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .side_in  (c1_side[i]),
            .vec_in   (c1_vec[i]),
            .side_out (c1_side[i+1]),
            .vec_out  (c1_vec[i+1])
        );
    end

    vda_gain_cell u_gain1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .side_in  (c1_side[NS]),
        .vec_in   (c1_vec[NS]),
        .side_out (g1_side),
        .vec_out  (g1_vec)
    );

    // Second length pass over (|cx,cy|, cz).
    always_comb
    begin
        c2_vec[0].x  = g1_vec.x;
        c2_vec[0].y  = g1_vec.a1;
        c2_vec[0].z  = '0;
        c2_vec[0].a0 = g1_vec.a0;
        c2_vec[0].a1 = '0;
    end
    assign c2_side[0] = g1_side;

    for (genvar i = 0; i < NS; i++)
    begin : g_pass2
        vda_cordic_cell #(.STAGE(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .side_in  (c2_side[i]),
            .vec_in   (c2_vec[i]),
            .side_out (c2_side[i+1]),
            .vec_out  (c2_vec[i+1])
        );
    end

    vda_gain_cell u_gain2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .side_in  (c2_side[NS]),
        .vec_in   (c2_vec[NS]),
        .side_out (g2_side),
        .vec_out  (g2_vec)
    );

    // Angle pass: atan2(dot, |cross|) accumulated in degrees.
    always_comb
    begin
        c3_vec[0].x  = g2_vec.x;
        c3_vec[0].y  = g2_vec.a0;
        c3_vec[0].z  = '0;
        c3_vec[0].a0 = '0;
        c3_vec[0].a1 = '0;
    end
    assign c3_side[0] = g2_side;

    for (genvar i = 0; i < NS; i++)
    begin : g_pass3
        vda_cordic_cell #(.STAGE(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .side_in  (c3_side[i]),
            .vec_in   (c3_vec[i]),
            .side_out (c3_side[i+1]),
            .vec_out  (c3_vec[i+1])
        );
    end

    // Round to Q8.8, saturate, and force zero for a zero vector.
    logic signed [ZW:0]   rounded;
    logic signed [ZW-16:0] q8;
    logic [15:0]          draft_next;
    logic [31:0]          out_data_reg;
    logic                 out_degen_reg;

    always_comb
    begin
        rounded = (ZW+1)'(c3_vec[NS].z) + (ZW+1)'(32768);
        q8      = (ZW-15)'(rounded >>> 16);
        if (c3_side[NS].degen)
            draft_next = '0;
        else if (q8 > (ZW-15)'(DEG90_Q8))
            draft_next = 16'(DEG90_Q8);
        else if (q8 < -(ZW-15)'(DEG90_Q8))
            draft_next = 16'(-DEG90_Q8);
        else
            draft_next = q8[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= c3_side[NS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg  <= {draft_next, c3_side[NS].tag};
            out_degen_reg <= c3_side[NS].degen;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_degen_reg;

endmodule
`default_nettype wire

// ===== rtl/vda_norm_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vda_norm_cell
// One step of the power-of-two scaling of dot and cross products.
// ----------------------------------------------------------------------------
module vda_norm_cell #(
    parameter int SHIFT = 1,
    parameter int MODE  = 0
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  en,
    input  wire vda_pkg::side_t  side_in,
    input  wire vda_pkg::quad_t  vec_in,
    output vda_pkg::side_t       side_out,
    output vda_pkg::quad_t       vec_out
);
    import vda_pkg::*;

    quad_t           shifted;
    quad_t           vec_next;
    logic [NW-1:0]   mag_or;
    logic            take;
    side_t           side_reg;
    quad_t           vec_reg;

    always_comb
    begin
        mag_or = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (MODE == MODE_LEFT)
                shifted[k] = vec_in[k] <<< SHIFT;
            else
                shifted[k] = $signed(vec_in[k]) >>> SHIFT;
            // The trial kind looks at the values as they would be after the shift.
            if (MODE == MODE_RIGHT_TRY)
                mag_or = mag_or | mag_w(shifted[k]);
            else
                mag_or = mag_or | mag_w(vec_in[k]);
        end
        if (MODE == MODE_LEFT)
            take = (mag_or >> (NORM_BIT - SHIFT)) == '0;
        else
            take = (mag_or >> NORM_BIT) != '0;
        vec_next = take ? shifted : vec_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else if (en)
            side_reg <= side_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            vec_reg <= vec_next;
    end

    assign side_out = side_reg;
    assign vec_out  = vec_reg;

endmodule
`default_nettype wire

// ===== rtl/vda_cordic_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vda_cordic_cell
// One vectoring iteration of the CORDIC chain, with its angle step.
// ----------------------------------------------------------------------------
module vda_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  en,
    input  wire vda_pkg::side_t  side_in,
    input  wire vda_pkg::cord_t  vec_in,
    output vda_pkg::side_t       side_out,
    output vda_pkg::cord_t       vec_out
);
    import vda_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = ZW'(atan_deg(STAGE));

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    cord_t                vec_next;
    side_t                side_reg;
    cord_t                vec_reg;

    always_comb
    begin
        dx       = vec_in.y >>> STAGE;
        dy       = vec_in.x >>> STAGE;
        vec_next = vec_in;
        if (vec_in.y > 0)
        begin
            vec_next.x = vec_in.x + dx;
            vec_next.y = vec_in.y - dy;
            vec_next.z = vec_in.z + ATAN;
        end
        else
        begin
            vec_next.x = vec_in.x - dx;
            vec_next.y = vec_in.y + dy;
            vec_next.z = vec_in.z - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else if (en)
            side_reg <= side_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            vec_reg <= vec_next;
    end

    assign side_out = side_reg;
    assign vec_out  = vec_reg;

endmodule
`default_nettype wire

// ===== rtl/vda_gain_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vda_gain_cell
// Removes the CORDIC gain from the vector length with one constant multiply.
// ----------------------------------------------------------------------------
module vda_gain_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  en,
    input  wire vda_pkg::side_t  side_in,
    input  wire vda_pkg::cord_t  vec_in,
    output vda_pkg::side_t       side_out,
    output vda_pkg::cord_t       vec_out
);
    import vda_pkg::*;

    localparam logic signed [GAIN_W-1:0] GAIN = GAIN_W'(INV_GAIN);

    logic signed [CW+GAIN_W-1:0] prod;
    cord_t                       vec_next;
    side_t                       side_reg;
    cord_t                       vec_reg;

    always_comb
    begin
        prod       = vec_in.x * GAIN;
        vec_next   = vec_in;
        vec_next.x = CW'(prod >>> GAIN_FRAC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else if (en)
            side_reg <= side_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            vec_reg <= vec_next;
    end

    assign side_out = side_reg;
    assign vec_out  = vec_reg;

endmodule
`default_nettype wire

// ===== rtl/vda_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vda_checker
// Port-level checks of the draft angle block, bound to its top level.
// ----------------------------------------------------------------------------
module vda_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire        m_tuser
);

    // A held result keeps its beat.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // A stalled output stops the whole pipeline, input included.
    a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // A zero vector gives a zero angle.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[31:16] == 16'd0)
        else $error("degenerate beat with nonzero angle");

    // The angle stays within plus and minus ninety degrees.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[31:16]) <= 16'sd23040) &&
                     ($signed(m_tdata[31:16]) >= -16'sd23040))
        else $error("draft angle out of range");

endmodule

bind vector_draft_angle vda_checker u_vda_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Draft angle block testbench
// Streams face normals through the block under several demolding directions
// and compares every result beat with an angle predicted by a bit-exact
// shift-add model, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module testbench;
    import vda_pkg::*;

    localparam int CB      = 16;
    localparam int STAGES  = 16;
    localparam int LATENCY = 3 * STAGES + 16;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] deg;
        logic        degen;
    } draft_t;

    class draft_scoreboard;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        draft_t pending[$];

        function new();
            dir_x = 16'sd0;
            dir_y = 16'sd0;
            dir_z = 16'sd32767;
        endfunction

        function longint atan_q24(int i);
            longint tbl[16] = '{754974720, 445687602, 235489088, 119537938, 60000934,
                30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367,
                234684, 117342, 58671, 29335};
            return tbl[i];
        endfunction

        function longint vec_length(longint x, longint y);
            longint dx;
            longint dy;
            if (x < 0)
                x = -x;
            for (int i = 0; i < STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x += dx;
                    y -= dy;
                end
                else
                begin
                    x -= dx;
                    y += dy;
                end
            end
            return (x * longint'(INV_GAIN)) >>> 20;
        endfunction

        function longint vec_angle(longint x, longint y);
            longint dx;
            longint dy;
            longint z;
            z = 0;
            for (int i = 0; i < STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x += dx;
                    y -= dy;
                    z += atan_q24(i);
                end
                else
                begin
                    x -= dx;
                    y += dy;
                    z -= atan_q24(i);
                end
            end
            return z;
        endfunction

        function void note_face(logic [15:0] tag, logic signed [15:0] nx,
                                logic signed [15:0] ny, logic signed [15:0] nz);
            longint ax, ay, az, bx, by, bz;
            longint dot, cx, cy, cz, big, clen, deg, q8;
            draft_t e;
            ax = nx; ay = ny; az = nz;
            bx = dir_x; by = dir_y; bz = dir_z;
            e.tag = tag;
            if ((ax == 0 && ay == 0 && az == 0) || (bx == 0 && by == 0 && bz == 0))
            begin
                e.deg = 16'd0;
                e.degen = 1'b1;
            end
            else
            begin
                dot = ax * bx + ay * by + az * bz;
                cx = ay * bz - az * by;
                cy = az * bx - ax * bz;
                cz = ax * by - ay * bx;
                for (int g = 0; g < 64; g++)
                begin
                    big = dot < 0 ? -dot : dot;
                    if ((cx < 0 ? -cx : cx) > big) big = cx < 0 ? -cx : cx;
                    if ((cy < 0 ? -cy : cy) > big) big = cy < 0 ? -cy : cy;
                    if ((cz < 0 ? -cz : cz) > big) big = cz < 0 ? -cz : cz;
                    if (big == 0)
                        break;
                    if (big >= (64'sd1 <<< 39))
                    begin
                        dot = dot >>> 1; cx = cx >>> 1; cy = cy >>> 1; cz = cz >>> 1;
                    end
                    else if (big < (64'sd1 <<< 38))
                    begin
                        dot *= 2; cx *= 2; cy *= 2; cz *= 2;
                    end
                    else
                        break;
                end
                clen = vec_length(vec_length(cx, cy), cz);
                deg = vec_angle(clen, dot);
                q8 = (deg + 32768) >>> 16;
                if (q8 > DEG90_Q8) q8 = DEG90_Q8;
                if (q8 < -DEG90_Q8) q8 = -DEG90_Q8;
                e.deg = q8[15:0];
                e.degen = 1'b0;
            end
            pending.push_back(e);
        endfunction

        // Returns a mask of mismatching fields: bit 3 no beat was expected.
        function int check_result(draft_t got, output draft_t want);
            int bad;
            bad = 0;
            want = '0;
            if (pending.size() == 0)
                return 8;
            want = pending.pop_front();
            if (got.tag != want.tag) bad |= 1;
            if (got.deg != want.deg) bad |= 2;
            if (got.degen != want.degen) bad |= 4;
            return bad;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    draft_scoreboard sb;
    int errors;
    int idle_pct;
    int stall_pct;
    int hold_cycles;

    vector_draft_angle #(.COMPONENT_BITS(CB), .CORDIC_STAGES(STAGES)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        #12000000;
        $display("Simulation FAILED");
        $finish;
    end

    task report(input string what, input draft_t got, input draft_t want);
        errors++;
        $display("mismatch %s: got tag %h deg %h degen %b, want tag %h deg %h degen %b",
                 what, got.tag, got.deg, got.degen, want.tag, want.deg, want.degen);
    endtask

    // Sink side: random stalls, or a long hold-off while hold_cycles runs down.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready = 1'b0;
            hold_cycles--;
        end
        else
            m_tready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        draft_t got;
        draft_t want;
        int bad;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_face(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tdata[63:48]);
            if (m_tvalid && m_tready)
            begin
                got.tag = m_tdata[15:0];
                got.deg = m_tdata[31:16];
                got.degen = m_tuser;
                bad = sb.check_result(got, want);
                if (bad & 8) report("unexpected beat", got, want);
                if (bad & 1) report("tag", got, want);
                if (bad & 2) report("angle", got, want);
                if (bad & 4) report("degenerate flag", got, want);
            end
        end
    end

    task send_face(input logic [15:0] tag, input logic [15:0] nx,
                   input logic [15:0] ny, input logic [15:0] nz);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {nz, ny, nx, tag};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task drain();
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    task write_reg(input logic [1:0] idx, input logic [15:0] val);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = {{16{val[15]}}, val};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_DIR_X: sb.dir_x = val;
            REG_DIR_Y: sb.dir_y = val;
            default:   sb.dir_z = val;
        endcase
    endtask

    task set_direction(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
        drain();
        write_reg(REG_DIR_X, x);
        write_reg(REG_DIR_Y, y);
        write_reg(REG_DIR_Z, z);
    endtask

    function logic [15:0] rand_comp();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 16'd0;
        else if (r < 3)
            return 16'($signed($urandom_range(64)) - 32);
        else if (r == 3)
            return $urandom_range(1) ? 16'h7fff : 16'h8000;
        return 16'($urandom);
    endfunction

    task random_faces(input int n);
        for (int i = 0; i < n; i++)
            send_face(16'($urandom), rand_comp(), rand_comp(), rand_comp());
    endtask

    task directed_faces();
        send_face(16'h0000, 16'h0000, 16'h0000, 16'h7fff);
        send_face(16'hffff, 16'h0000, 16'h0000, 16'h8000);
        send_face(16'h1234, 16'h7fff, 16'h0000, 16'h0000);
        send_face(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_face(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_face(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_face(16'h0002, 16'h0001, 16'h0000, 16'h0000);
        send_face(16'h0003, 16'h0000, 16'hffff, 16'h0001);
        send_face(16'h0004, 16'h5a82, 16'h0000, 16'h5a82);
        send_face(16'h0005, 16'h7fff, 16'h8000, 16'h0000);
    endtask

    initial
    begin
        sb = new();
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset direction, then the directed set under other directions.
        directed_faces();
        set_direction(16'h8000, 16'h8000, 16'h8000);
        directed_faces();
        set_direction(16'h0000, 16'h0000, 16'h0000);
        directed_faces();
        set_direction(16'h7fff, 16'h0000, 16'h0000);
        directed_faces();

        idle_pct = 0;   stall_pct = 0;  random_faces(200);
        idle_pct = 74;  stall_pct = 0;  random_faces(200);
        set_direction(16'h0000, 16'h7fff, 16'h8000);
        idle_pct = 0;   stall_pct = 74; random_faces(200);
        idle_pct = 7;   stall_pct = 7;  random_faces(200);

        // Long sink hold-off while the source keeps offering beats.
        idle_pct = 0;   stall_pct = 0;
        hold_cycles = 400;
        random_faces(200);

        set_direction(rand_comp(), rand_comp(), rand_comp());
        idle_pct = 7;   stall_pct = 74; random_faces(100);
        set_direction(16'h0001, 16'hffff, 16'h0000);
        idle_pct = 74;  stall_pct = 74; random_faces(100);

        drain();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
